// File: design/avd_pkg.sv
// Shared types, codes and constants of the synthesizer voice.
package avd_pkg;

  localparam int SAMPLE_RATE_DEF = 48000;
  localparam int PHASE_BITS_DEF  = 24;
  localparam int SINE_DEPTH_DEF  = 256;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_NOTE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_TRI    = 3'd2;
  localparam logic [2:0] WAVE_SAW    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;

  localparam logic [2:0] ST_ATTACK  = 3'd0;
  localparam logic [2:0] ST_DECAY   = 3'd1;
  localparam logic [2:0] ST_SUSTAIN = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_OFF     = 3'd4;

  localparam logic [2:0] REG_WAVEFORM = 3'd0;
  localparam logic [2:0] REG_ATTACK   = 3'd1;
  localparam logic [2:0] REG_DECAY    = 3'd2;
  localparam logic [2:0] REG_SUSTAIN  = 3'd3;
  localparam logic [2:0] REG_RELEASE  = 3'd4;
  localparam logic [2:0] REG_MASTER   = 3'd5;

  localparam logic [16:0] ENV_ONE    = 17'h10000;
  localparam logic [15:0] NOISE_SEED = 16'hACE1;
  localparam logic [16:0] SIN_A      = 17'd102944;
  localparam logic [16:0] SIN_B      = 17'd42334;
  localparam logic [16:0] SIN_C      = 17'd5210;
  // 24 * 65536 * 255 is split into a shift by 19 and a multiplication by the
  // reciprocal of 765, which is exact for the 25-bit shifted magnitude.
  localparam logic [25:0] OUT_RECIP   = 26'd44914691;
  localparam int          OUT_SHIFT   = 35;
  localparam longint      ATTACK_NUM  = 64'd1275 * 64'd65536;

  typedef struct packed {
    logic [2:0] waveform;
    logic [7:0] attack_time;
    logic [7:0] decay_time;
    logic [7:0] sustain_level;
    logic [7:0] release_time;
    logic [7:0] master_volume;
  } cfg_t;

  typedef struct packed {
    logic note_load;
    logic release_load;
    logic env_start;
    logic env_update;
    logic wave_form;
    logic sin1;
    logic sin2;
    logic sin3;
    logic sin4;
    logic mul1;
    logic mul2;
    logic mul3;
    logic out_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sine_sel;
    logic out_free;
  } status_t;

endpackage

// File: design/avd_in_if.sv
// Input channel of the voice: operation items with their payload.
interface avd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] phase_step;
  logic [4:0]  note_volume;
  logic        restart_envelope;

  modport source (output valid, op, phase_step, note_volume, restart_envelope, input ready);
  modport sink (input valid, op, phase_step, note_volume, restart_envelope, output ready);
endinterface

// File: design/avd_out_if.sv
// Output channel of the voice: one sample and envelope stage per tick.
interface avd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [2:0]         voice_stage;

  modport source (output valid, sample, voice_stage, input ready);
  modport sink (input valid, sample, voice_stage, output ready);
endinterface

// File: design/avd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module avd_div import avd_pkg::*; #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, dreg};
  assign ge    = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end
endmodule

// File: design/avd_datapath.sv
// Voice datapath: envelope, phase, waveform, shared multiplier and divider.
module avd_datapath import avd_pkg::*; #(
  parameter int SAMPLE_RATE_HZ   = SAMPLE_RATE_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  cmd_t         cmd,
  output status_t      status,
  input  logic [23:0]  phase_step,
  input  logic [4:0]   note_volume,
  input  logic         restart_envelope,
  avd_out_if.source    out_ch
);
  localparam int PB      = PHASE_BITS;
  localparam int LD      = $clog2(SINE_TABLE_DEPTH);
  localparam int SR_W    = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int DEN_W   = 8 + SR_W;
  localparam longint NUM_MAX = ATTACK_NUM + 64'd255 * longint'(SAMPLE_RATE_HZ);
  localparam int NUM_W   = $clog2(NUM_MAX + 1);

  logic [PB-1:0]  phase;
  logic [PB-1:0]  freq;
  logic [16:0]    env;
  logic [2:0]     stage;
  logic [4:0]     amp;
  logic [15:0]    noise;

  logic [16:0]    t;
  logic [16:0]    t2;
  logic [16:0]    inner;
  logic [15:0]    wmag;
  logic           wneg;
  logic [45:0]    acc;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  // Envelope increment numerator and divisor for the current stage.
  logic [7:0]         stage_time;
  logic [NUM_W-1:0]   env_num;
  logic [DEN_W-1:0]   env_den;
  logic [16:0]        sus;
  logic [16:0]        inc;
  logic signed [18:0] lev_up;
  logic signed [18:0] lev_dn;

  always_comb begin
    case (stage)
      ST_ATTACK: begin
        stage_time = cfg.attack_time;
        env_num    = NUM_W'(ATTACK_NUM);
      end
      ST_DECAY: begin
        stage_time = cfg.decay_time;
        env_num    = NUM_W'({(9'd255 - {1'b0, cfg.sustain_level}) << 1, 16'd0});
      end
      ST_RELEASE: begin
        stage_time = cfg.release_time;
        env_num    = NUM_W'({cfg.sustain_level, 16'd0});
      end
      default: begin
        stage_time = 8'd0;
        env_num    = '0;
      end
    endcase
  end

  assign env_den = DEN_W'(stage_time) * DEN_W'(SAMPLE_RATE_HZ);
  // s * 65536 / 255 equals s * 257, plus one only for full scale.
  assign sus = 17'(cfg.sustain_level) * 17'd257 + 17'(cfg.sustain_level == 8'd255);

  always_comb begin
    if (stage_time == 8'd0) begin
      inc = ENV_ONE;
    end else if (div_quot == '0) begin
      inc = 17'd1;
    end else begin
      inc = div_quot[16:0];
    end
  end

  assign lev_up = $signed({2'b00, env}) + $signed({2'b00, inc});
  assign lev_dn = $signed({2'b00, env}) - $signed({2'b00, inc});

  assign div_start = cmd.env_start;
  assign div_num   = env_num + NUM_W'(env_den) - 1'b1;
  assign div_den   = env_den;

  avd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Waveform terms taken from the phase.
  logic [PB+14:0]     pext;
  logic [15:0]        p15;
  logic signed [17:0] tri_d;
  logic signed [17:0] tri_abs;
  logic signed [17:0] tri_v;
  logic [LD-1:0]      k;
  logic [16:0]        t_base;
  logic [PB+23:0]     fext;

  assign pext    = {phase, 15'd0};
  assign p15     = 16'(pext >> PB);
  assign tri_d   = $signed({2'b00, p15}) * 18'sd2 - 18'sd32768;
  assign tri_abs = tri_d[17] ? -tri_d : tri_d;
  assign tri_v   = tri_abs * 18'sd2 - 18'sd32768;
  assign k       = LD'(phase >> (PB - LD));
  assign t_base  = 17'(k[LD-3:0]) << (18 - LD);
  assign fext    = {phase_step, PB'(0)};

  // One shared multiplier, its product registered by each step.
  logic [29:0] mul_a;
  logic [16:0] mul_b;
  logic [46:0] prod;
  logic [16:0] res;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sin1) begin
      mul_a = 30'(t);
      mul_b = t;
    end else if (cmd.sin2) begin
      mul_a = 30'(t2);
      mul_b = SIN_C;
    end else if (cmd.sin3) begin
      mul_a = 30'(t2);
      mul_b = inner;
    end else if (cmd.sin4) begin
      mul_a = 30'(t);
      mul_b = inner;
    end else if (cmd.mul1) begin
      mul_a = 30'(wmag);
      mul_b = 17'(amp);
    end else if (cmd.mul2) begin
      mul_a = acc[29:0];
      mul_b = 17'(cfg.master_volume);
    end else if (cmd.mul3) begin
      mul_a = acc[29:0];
      mul_b = env;
    end
  end

  assign prod = 47'(mul_a) * 47'(mul_b);
  assign res  = prod[33:17];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      freq  <= '0;
      env   <= '0;
      stage <= ST_OFF;
      amp   <= '0;
      noise <= NOISE_SEED;
    end else begin
      if (cmd.note_load) begin
        freq  <= PB'(fext >> 24);
        amp   <= note_volume;
        stage <= ST_ATTACK;
        if (restart_envelope) begin
          env <= '0;
        end
      end
      if (cmd.release_load) begin
        stage <= ST_RELEASE;
      end
      if (cmd.env_update) begin
        phase <= phase + freq;
        if (cfg.waveform == WAVE_NOISE) begin
          // Bit 15 of the seed still falls into bit 14 on the first shift.
          noise <= {1'b0, noise[15] | (noise[0] ^ noise[1]), noise[14:1]};
        end
        case (stage)
          ST_ATTACK: begin
            if (lev_up >= $signed({2'b00, ENV_ONE})) begin
              env   <= ENV_ONE;
              stage <= ST_DECAY;
            end else begin
              env <= lev_up[16:0];
            end
          end
          ST_DECAY: begin
            if (lev_dn <= $signed({2'b00, sus})) begin
              env   <= sus;
              stage <= ST_SUSTAIN;
            end else begin
              env <= lev_dn[16:0];
            end
          end
          ST_RELEASE: begin
            if (lev_dn <= 19'sd0) begin
              env   <= '0;
              stage <= ST_OFF;
            end else begin
              env <= lev_dn[16:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wave_form) begin
      case (cfg.waveform)
        WAVE_SINE: begin
          t    <= k[LD-2] ? ENV_ONE - t_base : t_base;
          wneg <= k[LD-1];
          wmag <= '0;
        end
        WAVE_SQUARE: begin
          wmag <= 16'd32768;
          wneg <= phase[PB-1];
        end
        WAVE_TRI: begin
          wneg <= tri_v[17];
          wmag <= tri_v[17] ? 16'(-tri_v) : tri_v[15:0];
        end
        WAVE_SAW: begin
          wmag <= p15;
          wneg <= 1'b0;
        end
        WAVE_NOISE: begin
          wmag <= 16'd32768;
          wneg <= !noise[0];
        end
        default: begin
          wmag <= '0;
          wneg <= 1'b0;
        end
      endcase
    end
    if (cmd.sin1) begin
      t2 <= prod[32:16];
    end
    if (cmd.sin2) begin
      inner <= SIN_B - prod[32:16];
    end
    if (cmd.sin3) begin
      inner <= SIN_A - prod[32:16];
    end
    if (cmd.sin4) begin
      wmag <= (res > 17'd32767) ? 16'd32767 : res[15:0];
    end
    if (cmd.mul1 || cmd.mul2 || cmd.mul3) begin
      acc <= prod[45:0];
    end
  end

  // The product never exceeds 44 bits, so the shifted magnitude fits 25 bits.
  logic [24:0] out_num;
  logic [50:0] out_prod;
  logic [15:0] scaled;

  assign out_num  = acc[43:19];
  assign out_prod = 51'(out_num) * 51'(OUT_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.out_start) begin
      scaled <= 16'(out_prod >> OUT_SHIFT);
    end
  end

  // Output register with saturation toward signed 16 bits.
  logic signed [15:0] sample_next;

  always_comb begin
    if (wneg) begin
      sample_next = (scaled > 16'd32768) ? -16'sd32768 : 16'(-scaled);
    end else begin
      sample_next = (scaled > 16'd32767) ? 16'sd32767 : 16'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.sample      <= sample_next;
      out_ch.voice_stage <= stage;
    end
  end

  assign status.div_done = div_done;
  assign status.sine_sel = (cfg.waveform == WAVE_SINE);
  assign status.out_free = !out_ch.valid || out_ch.ready;
endmodule

// File: design/avd_ctrl.sv
// Voice controller: sequences one tick through envelope, waveform and scaling.
module avd_ctrl import avd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic [1:0] in_op,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_ENV_START = 16'h0002,
    S_ENV_WAIT  = 16'h0004,
    S_ENV_UPD   = 16'h0008,
    S_WAVE      = 16'h0010,
    S_SIN1      = 16'h0020,
    S_SIN2      = 16'h0040,
    S_SIN3      = 16'h0080,
    S_SIN4      = 16'h0100,
    S_MUL1      = 16'h0200,
    S_MUL2      = 16'h0400,
    S_MUL3      = 16'h0800,
    S_OUT_START = 16'h1000,
    S_DONE      = 16'h4000,
    S_SPARE     = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_TICK:    state_next = S_ENV_START;
            OP_NOTE:    cmd.note_load = 1'b1;
            OP_RELEASE: cmd.release_load = 1'b1;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ENV_START: begin
        cmd.env_start = 1'b1;
        state_next    = S_ENV_WAIT;
      end
      S_ENV_WAIT: begin
        if (status.div_done) begin
          state_next = S_ENV_UPD;
        end
      end
      S_ENV_UPD: begin
        cmd.env_update = 1'b1;
        state_next     = S_WAVE;
      end
      S_WAVE: begin
        cmd.wave_form = 1'b1;
        state_next    = status.sine_sel ? S_SIN1 : S_MUL1;
      end
      S_SIN1: begin
        cmd.sin1   = 1'b1;
        state_next = S_SIN2;
      end
      S_SIN2: begin
        cmd.sin2   = 1'b1;
        state_next = S_SIN3;
      end
      S_SIN3: begin
        cmd.sin3   = 1'b1;
        state_next = S_SIN4;
      end
      S_SIN4: begin
        cmd.sin4   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_OUT_START;
      end
      S_OUT_START: begin
        cmd.out_start = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        // Hold the finished sample until the output register can take it.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// File: design/adsr_oscillator_voice.sv
// Top level of the synthesizer voice with its register port.
// Usage: items enter on in_ch (op, phase_step, note_volume,
// restart_envelope); each sample tick gives one transaction on out_ch
// carrying sample and voice_stage. Note start and release items are applied
// in the idle state and give no result; an unknown op is dropped. A sine
// tick passes through the envelope division, the envelope update, the
// waveform step, four polynomial steps, the note volume, master volume and
// envelope multiplications, the output scaling and the output load; the
// other waveforms skip the four polynomial steps. The envelope divider is
// bit-serial and 27 bits wide at the default sample rate. The output is
// scaled by a reciprocal multiplication. Items are taken one at a time.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls and a second result is ready, the
// sequencer holds it and in_ch stays not ready until out_ch drains.
// Registers are written over the APB port at byte address 4*index; the user
// must write them only while the voice is idle, which the block itself does
// not enforce; pready is always high. Synchronous reset sets the envelope to
// off, clears the phase, step and volume, reloads the noise seed, and sets the registers to their defaults.
module adsr_oscillator_voice import avd_pkg::*; #(
  parameter int SAMPLE_RATE_HZ   = SAMPLE_RATE_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  avd_in_if.sink      in_ch,
  avd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform      <= WAVE_SINE;
      cfg.attack_time   <= 8'd0;
      cfg.decay_time    <= 8'd0;
      cfg.sustain_level <= 8'd255;
      cfg.release_time  <= 8'd0;
      cfg.master_volume <= 8'd255;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WAVEFORM: cfg.waveform      <= pwdata[2:0];
        REG_ATTACK:   cfg.attack_time   <= pwdata[7:0];
        REG_DECAY:    cfg.decay_time    <= pwdata[7:0];
        REG_SUSTAIN:  cfg.sustain_level <= pwdata[7:0];
        REG_RELEASE:  cfg.release_time  <= pwdata[7:0];
        REG_MASTER:   cfg.master_volume <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WAVEFORM: prdata = 32'(cfg.waveform);
      REG_ATTACK:   prdata = 32'(cfg.attack_time);
      REG_DECAY:    prdata = 32'(cfg.decay_time);
      REG_SUSTAIN:  prdata = 32'(cfg.sustain_level);
      REG_RELEASE:  prdata = 32'(cfg.release_time);
      REG_MASTER:   prdata = 32'(cfg.master_volume);
      default:      prdata = 32'd0;
    endcase
  end

  avd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  avd_datapath #(
    .SAMPLE_RATE_HZ   (SAMPLE_RATE_HZ),
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .phase_step       (in_ch.phase_step),
    .note_volume      (in_ch.note_volume),
    .restart_envelope (in_ch.restart_envelope),
    .out_ch           (out_ch)
  );
endmodule
